// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the transmitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/pwct_pkg.sv =====
// Types and constants of the pulse-width command transmitter.
`timescale 1ns / 1ps
package pwct_pkg;

  localparam int unsigned HDR_W   = 20;
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned BIT_COUNT = 8;
  localparam int unsigned POS_W   = $clog2(BIT_COUNT);
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [HDR_W-1:0]   HEADER_RST = 20'd5000;
  localparam logic [PHASE_W-1:0] SHORT_RST  = 16'd400;
  localparam logic [PHASE_W-1:0] LONG_RST   = 16'd1200;
  localparam logic [CODE_W-1:0]  LOWEST_RST  = 8'd0;
  localparam logic [CODE_W-1:0]  HIGHEST_RST = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWEST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHEST = 3'd4;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SEND = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_LOW    = 2'd2,
    PH_HIGH   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_t;

  typedef struct packed {
    logic [HDR_W-1:0]   header_ticks;
    logic [PHASE_W-1:0] short_ticks;
    logic [PHASE_W-1:0] long_ticks;
    logic [CODE_W-1:0]  lowest_command;
    logic [CODE_W-1:0]  highest_command;
  } cfg_t;

  typedef struct packed {
    logic    line_level;
    logic    busy_res;
    status_t status;
    logic    finished;
  } result_t;

  function automatic logic [HDR_W-1:0] at_least_one(input logic [HDR_W-1:0] v);
    return (v == '0) ? HDR_W'(1) : v;
  endfunction

endpackage

// ===== hdl/pwct_core.sv =====
// Transmission state and per-request next-state and result logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pwct_core
  import pwct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              kind,
  input  logic [CODE_W-1:0] code,
  input  cfg_t              cfg,
  output result_t           res
);

  phase_t             phase_r,     phase_nxt;
  logic [POS_W-1:0]   bit_pos_r,   bit_pos_nxt;
  logic [HDR_W-1:0]   time_left_r, time_left_nxt;
  logic [CODE_W-1:0]  shift_r,     shift_nxt;
  logic               line_r,      line_nxt;
  status_t            status;
  logic               finished;
  logic [CODE_W-1:0]  shift_adv;
  logic [HDR_W-1:0]   short_ext, long_ext;

  assign short_ext = HDR_W'(cfg.short_ticks);
  assign long_ext  = HDR_W'(cfg.long_ticks);
  assign shift_adv = shift_r >> 1;

  always_comb begin
    phase_nxt     = phase_r;
    bit_pos_nxt   = bit_pos_r;
    time_left_nxt = time_left_r;
    shift_nxt     = shift_r;
    line_nxt      = line_r;
    status        = ST_OK;
    finished      = 1'b0;
    if (kind == KIND_SEND) begin
      if (phase_r != PH_IDLE) begin
        status = ST_BUSY;
      end else if (code < cfg.lowest_command || code > cfg.highest_command) begin
        status = ST_RANGE;
      end else begin
        shift_nxt     = code;
        bit_pos_nxt   = '0;
        phase_nxt     = PH_HEADER;
        line_nxt      = 1'b1;
        time_left_nxt = at_least_one(cfg.header_ticks);
      end
    end else if (phase_r != PH_IDLE) begin
      if (time_left_r > HDR_W'(1)) begin
        time_left_nxt = time_left_r - HDR_W'(1);
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            phase_nxt     = PH_LOW;
            line_nxt      = 1'b0;
            time_left_nxt = at_least_one(shift_r[0] ? short_ext : long_ext);
          end
          PH_LOW: begin
            phase_nxt     = PH_HIGH;
            line_nxt      = 1'b1;
            time_left_nxt = at_least_one(shift_r[0] ? long_ext : short_ext);
          end
          default: begin
            if (bit_pos_r == POS_W'(BIT_COUNT - 1)) begin
              phase_nxt     = PH_IDLE;
              line_nxt      = 1'b0;
              time_left_nxt = '0;
              bit_pos_nxt   = '0;
              finished      = 1'b1;
            end else begin
              bit_pos_nxt   = bit_pos_r + POS_W'(1);
              shift_nxt     = shift_adv;
              phase_nxt     = PH_LOW;
              line_nxt      = 1'b0;
              time_left_nxt = at_least_one(shift_adv[0] ? short_ext : long_ext);
            end
          end
        endcase
      end
    end
    res.line_level = line_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.status     = status;
    res.finished   = finished;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_pos_r   <= '0;
      time_left_r <= '0;
      shift_r     <= '0;
      line_r      <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      bit_pos_r   <= bit_pos_nxt;
      time_left_r <= time_left_nxt;
      shift_r     <= shift_nxt;
      line_r      <= line_nxt;
    end
  end

  `ASSERT_IMPLIES(a_idle_line_low, phase_r == PH_IDLE, !line_r && time_left_r == '0)
  `ASSERT_IMPLIES(a_busy_time_set, phase_r != PH_IDLE, time_left_r != '0)
  `ASSERT_NEXT(a_reject_holds, step && kind == KIND_SEND && phase_r != PH_IDLE,
    phase_r == $past(phase_r) && shift_r == $past(shift_r))

endmodule

// ===== hdl/pulse_width_command_transmitter.sv =====
// Top level of the pulse-width command transmitter: config registers and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Every request gives exactly one result, registered on acceptance and valid in the next cycle; a new
// request is taken each cycle while the result register is empty or being drained, so the
// block sustains one request per clock. A tick request advances the line timing by one
// unit; a send request starts a transmission if idle and in range. Configuration writes
// take effect on the next clock and apply from the next phase loaded.
module pulse_width_command_transmitter
  import pwct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [CODE_W-1:0]    in_command_code,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_line_level,
  output logic                 out_busy_res,
  output logic [1:0]           out_status,
  output logic                 out_finished,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HDR_W-1:0]     cfg_wdata
);

  cfg_t    cfg_r;
  result_t res;
  result_t out_r;
  logic    out_valid_r;
  logic    accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_ticks    <= HEADER_RST;
      cfg_r.short_ticks     <= SHORT_RST;
      cfg_r.long_ticks      <= LONG_RST;
      cfg_r.lowest_command  <= LOWEST_RST;
      cfg_r.highest_command <= HIGHEST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER:  cfg_r.header_ticks    <= cfg_wdata;
        REG_SHORT:   cfg_r.short_ticks     <= cfg_wdata[PHASE_W-1:0];
        REG_LONG:    cfg_r.long_ticks      <= cfg_wdata[PHASE_W-1:0];
        REG_LOWEST:  cfg_r.lowest_command  <= cfg_wdata[CODE_W-1:0];
        REG_HIGHEST: cfg_r.highest_command <= cfg_wdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  pwct_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (accept),
    .kind  (in_kind),
    .code  (in_command_code),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_line_level = out_r.line_level;
  assign out_busy_res   = out_r.busy_res;
  assign out_status     = out_r.status;
  assign out_finished   = out_r.finished;

  `ASSERT_NEXT(a_accept_gives_result, accept, out_valid_r)
  `ASSERT_IMPLIES(a_finish_ends_busy, out_valid_r && out_r.finished,
    !out_r.busy_res && !out_r.line_level && out_r.status == ST_OK)
  `ASSERT_IMPLIES(a_status_coded, out_valid_r,
    out_r.status == ST_OK || out_r.status == ST_RANGE || out_r.status == ST_BUSY)

endmodule

// ===== bench/line_report_checker.sv =====
// Checker for the pulse-width command transmitter: predicts each line report and compares.
`timescale 1ns / 1ps
module line_report_checker
  import pwct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_kind,
  input  logic [CODE_W-1:0]    in_command_code,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_line_level,
  input  logic                 out_busy_res,
  input  logic [1:0]           out_status,
  input  logic                 out_finished,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HDR_W-1:0]     cfg_wdata,
  output int                   failures,
  output int                   pending
);

  logic [HDR_W-1:0]   hdr_len;
  logic [PHASE_W-1:0] short_len;
  logic [PHASE_W-1:0] long_len;
  logic [CODE_W-1:0]  low_code;
  logic [CODE_W-1:0]  high_code;

  phase_t             phase;
  logic [POS_W-1:0]   bit_pos;
  logic [HDR_W-1:0]   ticks_left;
  logic [CODE_W-1:0]  shifter;
  logic               line_q;

  result_t            line_reports[$];
  result_t            want;

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic void load_ticks(input logic [HDR_W-1:0] n);
    ticks_left = n;
    if (ticks_left == '0) begin
      ticks_left = HDR_W'(1);
    end
  endfunction

  function automatic void start_low_half();
    phase  = PH_LOW;
    line_q = 1'b0;
    load_ticks(HDR_W'(shifter[0] ? short_len : long_len));
  endfunction

  function automatic result_t predict_report(input logic kind, input logic [CODE_W-1:0] code);
    result_t r;
    r.status   = ST_OK;
    r.finished = 1'b0;
    if (kind == KIND_SEND) begin
      if (phase != PH_IDLE) begin
        r.status = ST_BUSY;
      end else if (code < low_code || code > high_code) begin
        r.status = ST_RANGE;
      end else begin
        shifter = code;
        bit_pos = '0;
        phase   = PH_HEADER;
        line_q  = 1'b1;
        load_ticks(hdr_len);
      end
    end else if (phase != PH_IDLE) begin
      if (ticks_left > 1) begin
        ticks_left--;
      end else begin
        case (phase)
          PH_HEADER: begin
            start_low_half();
          end
          PH_LOW: begin
            phase  = PH_HIGH;
            line_q = 1'b1;
            load_ticks(HDR_W'(shifter[0] ? long_len : short_len));
          end
          default: begin
            if (bit_pos == POS_W'(BIT_COUNT - 1)) begin
              phase      = PH_IDLE;
              line_q     = 1'b0;
              ticks_left = '0;
              bit_pos    = '0;
              r.finished = 1'b1;
            end else begin
              bit_pos++;
              shifter = shifter >> 1;
              start_low_half();
            end
          end
        endcase
      end
    end
    r.line_level = line_q;
    r.busy_res   = (phase != PH_IDLE);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_len    = HEADER_RST;
      short_len  = SHORT_RST;
      long_len   = LONG_RST;
      low_code   = LOWEST_RST;
      high_code  = HIGHEST_RST;
      phase      = PH_IDLE;
      bit_pos    = '0;
      ticks_left = '0;
      shifter    = '0;
      line_q     = 1'b0;
      line_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEADER:  hdr_len   = cfg_wdata;
          REG_SHORT:   short_len = cfg_wdata[PHASE_W-1:0];
          REG_LONG:    long_len  = cfg_wdata[PHASE_W-1:0];
          REG_LOWEST:  low_code  = cfg_wdata[CODE_W-1:0];
          REG_HIGHEST: high_code = cfg_wdata[CODE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (line_reports.size() == 0) begin
          $error("unexpected report: line_level %0b busy_res %0b status %0d finished %0b",
                 out_line_level, out_busy_res, out_status, out_finished);
          failures++;
        end else begin
          want = line_reports.pop_front();
          if (out_line_level !== want.line_level) begin
            $error("line_level: expected %0b, got %0b", want.line_level, out_line_level);
            failures++;
          end
          if (out_busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, out_busy_res);
            failures++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            failures++;
          end
          if (out_finished !== want.finished) begin
            $error("finished: expected %0b, got %0b", want.finished, out_finished);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) begin
        line_reports.push_back(predict_report(in_kind, in_command_code));
      end
    end
    pending = line_reports.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the transmitter testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps
module testbench
  import pwct_pkg::*;
();

  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TOTAL  = 1900;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_kind = KIND_TICK;
  logic [CODE_W-1:0]    in_command_code = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_line_level;
  logic                 out_busy_res;
  logic [1:0]           out_status;
  logic                 out_finished;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER;
  logic [HDR_W-1:0]     cfg_wdata = '0;

  int failures;
  int pending;
  int send_idle_pct = 26;
  int recv_idle_pct = 71;
  int items_sent = 0;
  int stall_cycles = 0;

  logic [HDR_W-1:0]   hdr_set = HEADER_RST;
  logic [PHASE_W-1:0] short_set = SHORT_RST;
  logic [PHASE_W-1:0] long_set = LONG_RST;
  logic [CODE_W-1:0]  lo_set = LOWEST_RST;
  logic [CODE_W-1:0]  hi_set = HIGHEST_RST;

  pulse_width_command_transmitter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_command_code (in_command_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_level  (out_line_level),
    .out_busy_res    (out_busy_res),
    .out_status      (out_status),
    .out_finished    (out_finished),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  line_report_checker report_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_command_code (in_command_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_level  (out_line_level),
    .out_busy_res    (out_busy_res),
    .out_status      (out_status),
    .out_finished    (out_finished),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .failures        (failures),
    .pending         (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic kind, input logic [CODE_W-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_command_code <= code;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(KIND_TICK, CODE_W'($urandom));
  endtask

  // hold requests back until every report has come home
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HDR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_HEADER:  hdr_set   = value;
      REG_SHORT:   short_set = value[PHASE_W-1:0];
      REG_LONG:    long_set  = value[PHASE_W-1:0];
      REG_LOWEST:  lo_set    = value[CODE_W-1:0];
      REG_HIGHEST: hi_set    = value[CODE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
  endtask

  function automatic int tx_ticks();
    int h, s, l;
    h = (hdr_set == '0) ? 1 : int'(hdr_set);
    s = (short_set == '0) ? 1 : int'(short_set);
    l = (long_set == '0) ? 1 : int'(long_set);
    return h + int'(BIT_COUNT) * (s + l);
  endfunction

  task automatic reprogram();
    int pick;
    logic [CODE_W-1:0] lo, hi;
    settle();
    pick = $urandom_range(99);
    if (pick < 10) begin
      write_reg(REG_HEADER, '0);
    end else if (pick < 90) begin
      write_reg(REG_HEADER, HDR_W'($urandom_range(8, 1)));
    end else begin
      write_reg(REG_HEADER, HDR_W'($urandom_range(60, 9)));
    end
    write_reg(REG_SHORT, HDR_W'($urandom_range(3)));
    write_reg(REG_LONG, HDR_W'($urandom_range(6)));
    pick = $urandom_range(99);
    if (pick < 60) begin
      lo = CODE_W'($urandom_range(8'h30));
      hi = CODE_W'($urandom_range(8'hFF, 8'hD0));
    end else if (pick < 85) begin
      lo = '0;
      hi = '1;
    end else begin
      lo = CODE_W'($urandom);
      hi = CODE_W'($urandom);
    end
    write_reg(REG_LOWEST, HDR_W'(lo));
    write_reg(REG_HIGHEST, HDR_W'(hi));
    if ($urandom_range(99) < 15) begin
      write_reg(CFG_IDX_W'($urandom_range(7, int'(REG_HIGHEST) + 1)), HDR_W'($urandom));
    end
    end_writes();
  endtask

  task automatic run_sequence();
    int len, n;
    logic [CODE_W-1:0] code;
    if ($urandom_range(99) < 30) begin
      reprogram();
    end
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(8, 1)) send_item(1'($urandom), CODE_W'($urandom));
    end else begin
      if (lo_set <= hi_set && $urandom_range(99) < 85) begin
        code = lo_set + CODE_W'($urandom_range(int'(hi_set - lo_set)));
      end else begin
        code = CODE_W'($urandom);
      end
      send_item(KIND_SEND, code);
      len = tx_ticks();
      n = ($urandom_range(99) < 80) ? len + int'($urandom_range(3)) : int'($urandom_range(len));
      repeat (n) begin
        if ($urandom_range(99) < 6) begin
          send_item(KIND_SEND, CODE_W'($urandom));
        end else begin
          send_item(KIND_TICK, CODE_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(KIND_TICK, 8'hA5);

    settle();
    write_reg(REG_LOWEST, HDR_W'(8'h01));
    end_writes();
    send_item(KIND_SEND, 8'h00);

    settle();
    write_reg(REG_LOWEST, HDR_W'(8'h80));
    write_reg(REG_HIGHEST, HDR_W'(8'h7F));
    end_writes();
    send_item(KIND_SEND, 8'h80);
    send_item(KIND_SEND, 8'h7F);

    settle();
    write_reg(REG_HEADER, '1);
    write_reg(REG_LOWEST, HDR_W'(8'h40));
    write_reg(REG_HIGHEST, HDR_W'(8'h40));
    end_writes();
    send_item(KIND_SEND, 8'h41);
    send_item(KIND_SEND, 8'h3F);

    settle();
    write_reg(REG_HEADER, '0);
    write_reg(REG_SHORT, '0);
    write_reg(REG_LONG, HDR_W'(2));
    write_reg(REG_LOWEST, HDR_W'(8'h01));
    write_reg(REG_HIGHEST, HDR_W'(8'hFF));
    end_writes();
    send_item(KIND_SEND, 8'hFF);
    send_item(KIND_SEND, 8'h00);
    send_ticks(3);
    // retune mid-frame: takes effect from the next phase loaded
    settle();
    write_reg(REG_LONG, HDR_W'(1));
    end_writes();
    send_ticks(tx_ticks());

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (items_sent < (m + 1) * ITEM_TOTAL / 3) run_sequence();
    end

    // run out any frame left over, then load the longest phases into one bit
    settle();
    write_reg(REG_HEADER, HDR_W'(1));
    write_reg(REG_SHORT, HDR_W'(1));
    write_reg(REG_LONG, HDR_W'(1));
    end_writes();
    send_ticks(100);
    settle();
    write_reg(REG_SHORT, HDR_W'(16'hFFFF));
    write_reg(REG_LONG, HDR_W'(16'hFFFF));
    write_reg(REG_LOWEST, '0);
    write_reg(REG_HIGHEST, HDR_W'(8'hFF));
    end_writes();
    send_item(KIND_SEND, 8'h00);
    send_ticks(24);
    send_item(KIND_SEND, 8'h5A);

    settle();
    repeat (20) @(negedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
